// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sstf_pkg.sv =====
// Shared constants and control/status types of the SSTF seek-total block.
`default_nettype none

package sstf_pkg;

  localparam int MAX_REQUESTS = 16;
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int TRACK_W      = 16;
  localparam int SUM_W        = 20;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  // Register byte addresses (word index taken from paddr[2]).
  localparam logic REG_START_TRACK = 1'b0;

  typedef struct packed {
    logic load;    // store the accepted beat
    logic start;   // last beat accepted: set up the first pass
    logic scan;    // compare one stored entry against the best so far
    logic commit;  // move the head to the best entry
    logic finish;  // publish the result and clear the batch
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_end;  // current entry is the last stored one
    logic pass_end;  // current pass is the last one
    logic out_busy;  // result register still holds an untaken beat
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sstf_disk_seek_total_core.sv =====
// Top level of the SSTF seek-total block: register port, sequencer, datapath.
//
// Input channel (in_valid/in_stall, in_track, in_last): one request track per
// beat; in_last closes the batch. Up to MAX_REQUESTS requests are stored, more
// are dropped and reported through out_overflow.
// Non-last beats are accepted one per cycle while in_stall is low. After the last
// beat the head starts at start_track and n selection passes run over the n
// stored requests, each pass scanning every stored entry and then committing the
// nearest unserved one; in_stall stays high until the result has moved to the
// output register, and that move waits while the register holds an untaken beat.
// Result channel (out_valid/out_stall, out_total_movement, out_overflow): one
// beat per batch, held in an output register; a new batch may load while it
// waits, and a following result waits in the sequencer until it is taken.
// start_track sits at byte address 0 of the APB port; pready is always high.
// Reset (rst_n low, synchronous) empties the batch, clears the result valid
// and sets start_track to zero.
`default_nettype none

module sstf_disk_seek_total_core
  import sstf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [TRACK_W-1:0]  in_track,
  input  wire logic                in_last,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SUM_W-1:0]         out_total_movement,
  output logic                     out_overflow,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  logic [TRACK_W-1:0] start_track_r, start_track_nxt;
  logic               reg_hit;
  ctl_cmd_t           cmd;
  dp_stat_t           stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_START_TRACK);

  always_comb begin
    start_track_nxt = start_track_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      start_track_nxt = pwdata[TRACK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_track_r <= '0;
    end else begin
      start_track_r <= start_track_nxt;
    end
  end

  assign prdata = reg_hit ? PDATA_W'(start_track_r) : '0;

  sstf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  sstf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_track           (in_track),
    .start_track        (start_track_r),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_total_movement (out_total_movement),
    .out_overflow       (out_overflow)
  );

endmodule

`default_nettype wire

// ===== hdl/sstf_ctrl.sv =====
// Sequencer for loading, the selection passes and result hand-off.
`default_nettype none

module sstf_ctrl
  import sstf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_stall,
  output ctl_cmd_t      cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = stat.pass_end ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sstf_dp.sv =====
// Request store, served flags, nearest-entry search and movement accumulator.
`default_nettype none

module sstf_dp
  import sstf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctl_cmd_t            cmd,
  output dp_stat_t                 stat,
  input  wire logic [TRACK_W-1:0]  in_track,
  input  wire logic [TRACK_W-1:0]  start_track,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic [SUM_W-1:0]         out_total_movement,
  output logic                     out_overflow
);

  logic [TRACK_W-1:0]      store_r [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] served_r;
  logic [CNT_W-1:0]        count_r;
  logic                    dropped_r;
  logic [TRACK_W-1:0]      head_r;
  logic [SUM_W-1:0]        sum_r;
  logic [IDX_W-1:0]        scan_idx_r;
  logic [IDX_W-1:0]        pass_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic [TRACK_W-1:0]      best_trk_r;
  logic [TRACK_W-1:0]      best_dist_r;
  logic                    found_r;
  logic                    out_valid_r;
  logic [SUM_W-1:0]        out_sum_r;
  logic                    out_ovf_r;

  logic [IDX_W-1:0]   count_m1;
  logic [TRACK_W-1:0] entry;
  logic [TRACK_W-1:0] seek_gap;
  logic               take;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_sat;
  logic               has_room;

  assign count_m1 = count_r[IDX_W-1:0] - IDX_W'(1);
  assign has_room = (count_r < CNT_W'(MAX_REQUESTS));
  assign entry    = store_r[scan_idx_r];
  assign seek_gap = (head_r >= entry) ? (head_r - entry) : (entry - head_r);
  // strict compare keeps the earliest entry on a tie
  assign take     = !served_r[scan_idx_r] && (!found_r || (seek_gap < best_dist_r));
  assign sum_ext  = {1'b0, sum_r} + (SUM_W + 1)'(best_dist_r);
  assign sum_sat  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  assign stat.scan_end = (scan_idx_r == count_m1);
  assign stat.pass_end = (pass_r == count_m1);
  assign stat.out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      store_r[count_r[IDX_W-1:0]] <= in_track;
    end
    if (cmd.scan && take) begin
      best_idx_r  <= scan_idx_r;
      best_trk_r  <= entry;
      best_dist_r <= seek_gap;
    end
    if (cmd.finish) begin
      out_sum_r <= sum_r;
      out_ovf_r <= dropped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      served_r    <= '0;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      head_r      <= '0;
      sum_r       <= '0;
      scan_idx_r  <= '0;
      pass_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (has_room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (cmd.start) begin
        head_r     <= start_track;
        sum_r      <= '0;
        scan_idx_r <= '0;
        pass_r     <= '0;
        found_r    <= 1'b0;
      end
      if (cmd.scan) begin
        if (take) begin
          found_r <= 1'b1;
        end
        if (!stat.scan_end) begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
        end
      end
      if (cmd.commit) begin
        served_r[best_idx_r] <= 1'b1;
        head_r               <= best_trk_r;
        sum_r                <= sum_sat;
        found_r              <= 1'b0;
        scan_idx_r           <= '0;
        pass_r               <= pass_r + IDX_W'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        served_r    <= '0;
        count_r     <= '0;
        dropped_r   <= 1'b0;
        sum_r       <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_total_movement = out_sum_r;
  assign out_overflow       = out_ovf_r;

endmodule

`default_nettype wire

// ===== hdl/sstf_chk.sv =====
// Port-level checker for the SSTF seek-total block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module sstf_chk
  import sstf_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               in_last,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [SUM_W-1:0]   out_total_movement,
  input wire logic               out_overflow
);

  logic           last_beat;
  logic [SUM_W:0] out_beat;

  assign last_beat = in_valid && !in_stall && in_last;
  assign out_beat  = {out_overflow, out_total_movement};

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped")
  `ASSERT_CLK(a_out_stable, out_valid && out_stall |=> $stable(out_beat), "stalled beat changed")
  `ASSERT_CLK(a_busy_after_last, last_beat |=> in_stall, "input taken during search")
  `ASSERT_CLK(a_no_early_result, last_beat |=> !$rose(out_valid), "result too early")
  `ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sstf_disk_seek_total_core sstf_chk u_chk (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the SSTF seek-total block: directed and random batches.
`timescale 1ns / 100ps

module tb_top
  import sstf_pkg::*;
();

  localparam int unsigned SUM_LIMIT = (1 << SUM_W) - 1;
  localparam int SETTLE_CYCLES = MAX_REQUESTS * (MAX_REQUESTS + 1) + 1 + 32;
  localparam logic [PADDR_W-1:0] ADDR_START_TRACK = {REG_START_TRACK, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE = {~REG_START_TRACK, 2'b00};
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    TRK_SPREAD,
    TRK_CLUSTER,
    TRK_EDGE
  } track_mode_t;

  typedef struct {
    logic [SUM_W-1:0] total;
    logic             overflow;
  } seek_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TRACK_W-1:0] in_track = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SUM_W-1:0] out_total_movement;
  logic out_overflow;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // predictor state
  logic [TRACK_W-1:0] start_track_shadow = '0;
  logic [TRACK_W-1:0] batch_tracks[$];
  bit batch_dropped = 1'b0;
  seek_result_t expected_seeks[$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int calm_left = 0;

  sstf_disk_seek_total_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_track           (in_track),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_total_movement (out_total_movement),
    .out_overflow       (out_overflow),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // Walk the batch in shortest-seek order from the configured start track.
  function automatic logic [SUM_W-1:0] sstf_seek_total();
    bit served [MAX_REQUESTS];
    logic [TRACK_W-1:0] head;
    int unsigned sum;
    int unsigned gap;
    int unsigned best_dist;
    int best;
    head = start_track_shadow;
    sum = 0;
    foreach (served[k]) served[k] = 1'b0;
    for (int pass = 0; pass < batch_tracks.size(); pass++) begin
      best = -1;
      best_dist = 0;
      for (int j = 0; j < batch_tracks.size(); j++) begin
        if (!served[j]) begin
          gap = (head >= batch_tracks[j]) ? head - batch_tracks[j] : batch_tracks[j] - head;
          // strict compare keeps the earliest loaded entry on a tie
          if (best < 0 || gap < best_dist) begin
            best = j;
            best_dist = gap;
          end
        end
      end
      served[best] = 1'b1;
      head = batch_tracks[best];
      sum += best_dist;
      if (sum > SUM_LIMIT) sum = SUM_LIMIT;
    end
    return sum[SUM_W-1:0];
  endfunction

  function automatic void record_request(input logic [TRACK_W-1:0] trk, input logic lst);
    seek_result_t res;
    if (batch_tracks.size() < MAX_REQUESTS) batch_tracks.push_back(trk);
    else batch_dropped = 1'b1;
    if (lst) begin
      res.total = sstf_seek_total();
      res.overflow = batch_dropped;
      expected_seeks.push_back(res);
      batch_tracks.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  function automatic logic [TRACK_W-1:0] pick_track(input track_mode_t mode,
                                                    input logic [TRACK_W-1:0] base);
    logic [TRACK_W-1:0] trk;
    case (mode)
      TRK_CLUSTER: trk = base + TRACK_W'($urandom_range(0, 15)) - TRACK_W'(8);
      TRK_EDGE: begin
        case ($urandom_range(0, 4))
          0: trk = '0;
          1: trk = 16'd1;
          2: trk = 16'hFFFE;
          3: trk = 16'hFFFF;
          default: trk = 16'h8000;
        endcase
      end
      default: trk = TRACK_W'($urandom);
    endcase
    return trk;
  endfunction

  // Receiver: long hold-offs on request, calm stretches, random stalls otherwise.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (calm_left != 0) begin
      out_stall <= 1'b0;
      calm_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 80);
    end
  end

  // Compare each result beat with the oldest expected seek total.
  always @(posedge clk) begin
    seek_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_seeks.size() == 0) begin
        note_failure($sformatf("unexpected result beat: total %0d overflow %0b",
                               out_total_movement, out_overflow));
      end else begin
        exp_res = expected_seeks.pop_front();
        if (out_total_movement !== exp_res.total || out_overflow !== exp_res.overflow)
          note_failure($sformatf("result mismatch: expected total %0d overflow %0b, got %0d %0b",
                                 exp_res.total, exp_res.overflow,
                                 out_total_movement, out_overflow));
      end
    end
  end

  task automatic send_request(input logic [TRACK_W-1:0] trk, input logic lst, input bit no_gap);
    while (!no_gap && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_track <= trk;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_request(trk, lst);
  endtask

  task automatic apb_transfer(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_start_track();
    logic [PDATA_W-1:0] rdata;
    apb_transfer(1'b0, ADDR_START_TRACK, '0, rdata);
    if (rdata[TRACK_W-1:0] !== start_track_shadow)
      note_failure($sformatf("start_track read: expected %0d, got %0d",
                             start_track_shadow, rdata[TRACK_W-1:0]));
  endtask

  // Upper data bits are random; only the low track bits should stick.
  task automatic write_start_track(input logic [TRACK_W-1:0] trk);
    logic [PDATA_W-1:0] rdata;
    apb_transfer(1'b1, ADDR_START_TRACK, {16'($urandom), trk}, rdata);
    start_track_shadow = trk;
    check_start_track();
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_seeks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_register_port();
    logic [PDATA_W-1:0] rdata;
    check_start_track();
    write_start_track(16'hFFFF);
    write_start_track(16'h0000);
    // a write to the unused word must leave start_track alone
    apb_transfer(1'b1, ADDR_SPARE, $urandom, rdata);
    check_start_track();
  endtask

  task automatic test_directed_batches();
    // tie between 110 and 90: the earlier-loaded 110 must win
    write_start_track(16'd100);
    send_request(16'd110, 1'b0, 1'b1);
    send_request(16'd90, 1'b0, 1'b1);
    send_request(16'd130, 1'b1, 1'b1);
    // track extremes, with a duplicate
    send_request(16'h0000, 1'b0, 1'b1);
    send_request(16'hFFFF, 1'b0, 1'b1);
    send_request(16'h0000, 1'b1, 1'b1);
    wait_for_results();
    // single request, full stroke
    write_start_track(16'hFFFF);
    send_request(16'h0000, 1'b1, 1'b1);
    wait_for_results();
    // store full: the last request is dropped but the batch still closes
    write_start_track(16'h0000);
    for (int k = 0; k <= MAX_REQUESTS; k++)
      send_request(TRACK_W'($urandom), k == MAX_REQUESTS, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int n_items, input int gap_pct, input int hold_pct,
                                     input logic [TRACK_W-1:0] start);
    int sent;
    int size;
    int roll;
    track_mode_t mode;
    logic [TRACK_W-1:0] base;
    bit calm;
    write_start_track(start);
    send_idle_pct = gap_pct;
    stall_pct = hold_pct;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) size = 1;
      else if (roll < 70) size = $urandom_range(2, 8);
      else if (roll < 90) size = $urandom_range(9, MAX_REQUESTS);
      else size = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 6);
      roll = $urandom_range(0, 9);
      mode = (roll < 5) ? TRK_SPREAD : (roll < 8) ? TRK_CLUSTER : TRK_EDGE;
      base = TRACK_W'($urandom);
      calm = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < size; k++)
        send_request(pick_track(mode, base), k == size - 1, calm);
      sent += size;
    end
    wait_for_results();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // Hold the result side off long enough that the input side backs up.
  task automatic test_backpressure();
    write_start_track(TRACK_W'($urandom));
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1500;
    for (int b = 0; b < 4; b++)
      for (int k = 0; k < MAX_REQUESTS; k++)
        send_request(TRACK_W'($urandom), k == MAX_REQUESTS - 1, 1'b1);
    wait_for_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_port();
    test_directed_batches();
    test_random_traffic(125, 0, 0, 16'h0000);
    test_random_traffic(125, 58, 0, 16'hFFFF);
    test_random_traffic(125, 0, 58, TRACK_W'($urandom));
    test_random_traffic(125, 17, 17, 16'h8000);
    test_backpressure();
    wait_for_results();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
